/* design/mbrd_pkg.sv */
// Shared types, constants and the CRC-16 byte step for the dual-ID Modbus RTU slave.
`timescale 1ns / 1ps
package mbrd_pkg;

  typedef logic [7:0]  byte_t;
  typedef logic [15:0] word_t;

  localparam word_t CRC_POLY   = 16'hA001;
  localparam word_t CRC_PRESET = 16'hFFFF;
  localparam byte_t EXC_FLAG   = 8'h80;

  localparam byte_t FN_READ     = 8'd3;
  localparam byte_t FN_WRITE1   = 8'd6;
  localparam byte_t FN_WRITEN   = 8'd16;

  localparam byte_t EXC_FUNC  = 8'd1;
  localparam byte_t EXC_ADDR  = 8'd2;
  localparam byte_t EXC_VALUE = 8'd3;

  localparam logic [1:0] CFG_ID_FIRST  = 2'd0;
  localparam logic [1:0] CFG_ID_SECOND = 2'd1;
  localparam logic [1:0] CFG_REG_COUNT = 2'd2;

  localparam int MIN_FRAME      = 8;
  localparam int WRN_OVERHEAD   = 9;
  localparam int READ_OVERHEAD  = 5;

  // One byte through the reflected CRC-16, eight shift steps.
  function automatic word_t crc_byte(input word_t c_in, input byte_t d);
    word_t c;
    c = c_in ^ {8'h00, d};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

/* design/mbrd_bank.sv */
// One holding-register bank: a synchronous RAM with per-entry valid bits so it reads zero after reset.
`timescale 1ns / 1ps
module mbrd_bank #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  mbrd_pkg::word_t   wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output mbrd_pkg::word_t   rd_data
);
  import mbrd_pkg::*;

  word_t             mem [DEPTH];
  logic [DEPTH-1:0]  valid_r;
  word_t             rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= valid_r[rd_addr] ? mem[rd_addr] : '0;
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* design/modbus_rtu_dual_id_slave.sv */
// Top level of the dual-ID Modbus RTU slave: frame store, frame checker and reply sequencer.
`timescale 1ns / 1ps
// Received bytes are written into a frame store, one word per cycle while the
// block is idle; a byte without the frame-end flag gives no result. The byte
// flagged frame_end closes the frame: the sequencer then walks the frame store
// through its one read port (one byte per cycle) to check the CRC, decides,
// writes the register bank for an addressed function 6 or 16 (function 16 one
// register at a time, frame-store bound) and, unless broadcast, streams the
// reply out one word per cycle while out_stall is low, with a bank read step
// before each register's data, bound by the bank read port. Frames that are
// too long, short, addressed elsewhere or corrupt give one status word with
// tx_valid low. No new byte is taken while a frame is being served, but the
// last output word may still wait in the output register while the next
// frame's bytes come in. The banks read zero after reset through per-entry
// valid bits; no clearing pass is needed. Configuration writes are taken at
// any time but are meant for idle periods only.
module modbus_rtu_dual_id_slave #(
  parameter int FRAME_BYTES = 64,
  parameter int REG_WORDS   = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  mbrd_pkg::byte_t     cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  mbrd_pkg::byte_t     in_rx_byte,
  input  logic                in_frame_end,
  output logic                out_valid,
  input  logic                out_stall,
  output mbrd_pkg::byte_t     out_tx_byte,
  output logic                out_tx_valid,
  output logic                out_tx_last,
  output mbrd_pkg::word_t     out_error_count
);
  import mbrd_pkg::*;

  localparam int NW  = $clog2(FRAME_BYTES + 1);
  localparam int SAW = $clog2(FRAME_BYTES);
  localparam int AW  = (REG_WORDS > 1) ? $clog2(REG_WORDS) : 1;
  localparam int QW  = $clog2(REG_WORDS + 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SCAN   = 4'd1;
  localparam logic [3:0] S_DECIDE = 4'd2;
  localparam logic [3:0] S_STAT   = 4'd3;
  localparam logic [3:0] S_HEAD   = 4'd4;
  localparam logic [3:0] S_RDADR  = 4'd5;
  localparam logic [3:0] S_RDHI   = 4'd6;
  localparam logic [3:0] S_RDLO   = 4'd7;
  localparam logic [3:0] S_CRCL   = 4'd8;
  localparam logic [3:0] S_CRCH   = 4'd9;
  localparam logic [3:0] S_WRRD   = 4'd10;
  localparam logic [3:0] S_WRHI   = 4'd11;
  localparam logic [3:0] S_WRLO   = 4'd12;

  localparam logic [1:0] K_EXC  = 2'd0;
  localparam logic [1:0] K_READ = 2'd1;
  localparam logic [1:0] K_ECHO = 2'd2;

  // Configuration registers.
  byte_t      sid1_r, sid2_r;
  logic [6:0] rcnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sid1_r <= 8'd1;
      sid2_r <= 8'd2;
      rcnt_r <= 7'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ID_FIRST:  sid1_r <= cfg_data;
        CFG_ID_SECOND: sid2_r <= cfg_data;
        CFG_REG_COUNT: rcnt_r <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Sequencer state.
  logic [3:0]    state_r, state_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt, n_r, n_nxt;
  logic          ovf_r, ovf_nxt;
  logic [NW-1:0] scan_idx_r, scan_idx_nxt, pidx_r, pidx_nxt;
  logic          pv_r, pv_nxt;
  byte_t         hdr_r [7];
  byte_t         hdr_nxt [7];
  word_t         crc_r, crc_nxt, ocrc_r, ocrc_nxt;
  byte_t         clo_r, clo_nxt, chi_r, chi_nxt;
  word_t         errors_r, errors_nxt;
  logic [1:0]    kind_r, kind_nxt;
  byte_t         code_r, code_nxt;
  logic [2:0]    hidx_r, hidx_nxt;
  logic [QW-1:0] ri_r, ri_nxt;
  byte_t         whi_r, whi_nxt;
  logic          sel2_r, sel2_nxt, bank_en_r, bank_en_nxt, bcast_r, bcast_nxt;

  // Output register.
  logic   out_valid_r, out_valid_nxt, out_tx_valid_r, out_tx_valid_nxt;
  logic   out_tx_last_r, out_tx_last_nxt;
  byte_t  out_tx_byte_r, out_tx_byte_nxt;
  word_t  out_err_r, out_err_nxt;

  // Frame store.
  byte_t          store_mem [FRAME_BYTES];
  byte_t          srd_r;
  logic           st_we, st_re;
  logic [SAW-1:0] st_waddr, st_raddr;

  always_ff @(posedge clk) begin
    if (st_we) begin
      store_mem[st_waddr] <= in_rx_byte;
    end
    if (st_re) begin
      srd_r <= store_mem[st_raddr];
    end
  end

  // Register banks.
  logic          bk_wr, bk_rd;
  logic [AW-1:0] bk_waddr, bk_raddr;
  word_t         bk_wdata, rd1, rd2, bk_rdata;

  mbrd_bank #(.DEPTH(REG_WORDS), .AW(AW)) u_bank_one (
    .clk(clk), .rst_n(rst_n),
    .wr_en(bk_wr & bank_en_nxt & ~sel2_nxt), .wr_addr(bk_waddr), .wr_data(bk_wdata),
    .rd_en(bk_rd & ~sel2_r), .rd_addr(bk_raddr), .rd_data(rd1)
  );

  mbrd_bank #(.DEPTH(REG_WORDS), .AW(AW)) u_bank_two (
    .clk(clk), .rst_n(rst_n),
    .wr_en(bk_wr & bank_en_nxt & sel2_nxt), .wr_addr(bk_waddr), .wr_data(bk_wdata),
    .rd_en(bk_rd & sel2_r), .rd_addr(bk_raddr), .rd_data(rd2)
  );

  assign bk_rdata = sel2_r ? rd2 : rd1;

  // Decoded frame header.
  word_t         start_w, qty_w;
  logic [16:0]   end_w, regs_w, rlen_w;
  logic          can_emit, emit, e_valid, e_last;
  byte_t         e_byte;
  logic          hit1, hit2, bcast_w, crc_ok;
  logic [15:0]   acc_addr;
  logic          in_acc;

  assign start_w  = {hdr_r[2], hdr_r[3]};
  assign qty_w    = {hdr_r[4], hdr_r[5]};
  assign end_w    = {1'b0, start_w} + {1'b0, qty_w};
  assign regs_w   = ({10'd0, rcnt_r} > 17'(REG_WORDS)) ? 17'(REG_WORDS) : {10'd0, rcnt_r};
  assign rlen_w   = {qty_w, 1'b0} + 17'(READ_OVERHEAD);
  assign bcast_w  = (hdr_r[0] == 8'd0);
  assign hit1     = (hdr_r[0] == sid1_r);
  assign hit2     = !hit1 && (hdr_r[0] == sid2_r);
  assign crc_ok   = (crc_r == {chi_r, clo_r});
  assign acc_addr = start_w + 16'(ri_r);
  assign can_emit = !out_valid_r || !out_stall;
  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    ovf_nxt      = ovf_r;
    n_nxt        = n_r;
    scan_idx_nxt = scan_idx_r;
    pidx_nxt     = pidx_r;
    pv_nxt       = 1'b0;
    for (int k = 0; k < 7; k++) hdr_nxt[k] = hdr_r[k];
    crc_nxt      = crc_r;
    ocrc_nxt     = ocrc_r;
    clo_nxt      = clo_r;
    chi_nxt      = chi_r;
    errors_nxt   = errors_r;
    kind_nxt     = kind_r;
    code_nxt     = code_r;
    hidx_nxt     = hidx_r;
    ri_nxt       = ri_r;
    whi_nxt      = whi_r;
    sel2_nxt     = sel2_r;
    bank_en_nxt  = bank_en_r;
    bcast_nxt    = bcast_r;
    st_we        = 1'b0;
    st_re        = 1'b0;
    st_waddr     = cnt_r[SAW-1:0];
    st_raddr     = scan_idx_r[SAW-1:0];
    bk_wr        = 1'b0;
    bk_rd        = 1'b0;
    bk_waddr     = acc_addr[AW-1:0];
    bk_raddr     = acc_addr[AW-1:0];
    bk_wdata     = qty_w;
    emit         = 1'b0;
    e_byte       = '0;
    e_valid      = 1'b1;
    e_last       = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (!ovf_r) begin
            if (cnt_r >= NW'(FRAME_BYTES)) begin
              ovf_nxt = 1'b1;
            end else begin
              st_we   = 1'b1;
              cnt_nxt = cnt_r + 1'b1;
            end
          end
          if (in_frame_end) begin
            n_nxt   = cnt_nxt;
            cnt_nxt = '0;
            ovf_nxt = 1'b0;
            if (ovf_r || (cnt_r >= NW'(FRAME_BYTES))) begin
              errors_nxt = errors_r + 1'b1;
              state_nxt  = S_STAT;
            end else if (n_nxt < NW'(MIN_FRAME)) begin
              state_nxt = S_STAT;
            end else begin
              scan_idx_nxt = '0;
              crc_nxt      = CRC_PRESET;
              state_nxt    = S_SCAN;
            end
          end
        end
      end

      S_SCAN: begin
        // Reads run one address ahead of the byte being checked.
        if (scan_idx_r < n_r) begin
          st_re        = 1'b1;
          scan_idx_nxt = scan_idx_r + 1'b1;
          pv_nxt       = 1'b1;
          pidx_nxt     = scan_idx_r;
        end
        if (pv_r) begin
          if (pidx_r < NW'(7)) hdr_nxt[pidx_r[2:0]] = srd_r;
          if (pidx_r < n_r - NW'(2)) crc_nxt = crc_byte(crc_r, srd_r);
          if (pidx_r == n_r - NW'(2)) clo_nxt = srd_r;
          if (pidx_r == n_r - NW'(1)) begin
            chi_nxt   = srd_r;
            state_nxt = S_DECIDE;
          end
        end
      end

      S_DECIDE: begin
        sel2_nxt    = hit2;
        bank_en_nxt = hit1 || hit2;
        bcast_nxt   = bcast_w;
        hidx_nxt    = '0;
        ri_nxt      = '0;
        ocrc_nxt    = CRC_PRESET;
        state_nxt   = S_STAT;
        if ((!hit1 && !hit2 && !bcast_w) || !crc_ok) begin
          state_nxt = S_STAT;
        end else if (hdr_r[1] == FN_READ && !bcast_w) begin
          if ({1'b0, start_w} >= regs_w) begin
            code_nxt = EXC_ADDR;
          end else if (end_w > regs_w || rlen_w > 17'(FRAME_BYTES)) begin
            code_nxt = EXC_VALUE;
          end else begin
            code_nxt = '0;
          end
          if (code_nxt != '0) begin
            errors_nxt = errors_r + 1'b1;
            kind_nxt   = K_EXC;
          end else begin
            kind_nxt   = K_READ;
          end
          state_nxt = S_HEAD;
        end else if (hdr_r[1] == FN_WRITE1) begin
          if ({1'b0, start_w} >= regs_w) begin
            errors_nxt = errors_r + 1'b1;
            code_nxt   = EXC_ADDR;
            kind_nxt   = K_EXC;
            state_nxt  = bcast_w ? S_STAT : S_HEAD;
          end else begin
            bk_wr     = 1'b1;
            bk_waddr  = start_w[AW-1:0];
            bk_wdata  = qty_w;
            kind_nxt  = K_ECHO;
            state_nxt = bcast_w ? S_STAT : S_HEAD;
          end
        end else if (hdr_r[1] == FN_WRITEN) begin
          if ({1'b0, hdr_r[6]} + 9'(WRN_OVERHEAD) != 9'(n_r)) begin
            errors_nxt = errors_r + 1'b1;
            state_nxt  = S_STAT;
          end else if ({1'b0, start_w} >= regs_w ||
                       end_w > regs_w || {9'd0, hdr_r[6]} != {qty_w, 1'b0}) begin
            errors_nxt = errors_r + 1'b1;
            code_nxt   = ({1'b0, start_w} >= regs_w) ? EXC_ADDR : EXC_VALUE;
            kind_nxt   = K_EXC;
            state_nxt  = bcast_w ? S_STAT : S_HEAD;
          end else begin
            kind_nxt = K_ECHO;
            if (qty_w == '0 || !(hit1 || hit2)) begin
              state_nxt = bcast_w ? S_STAT : S_HEAD;
            end else begin
              state_nxt = S_WRRD;
            end
          end
        end else begin
          errors_nxt = errors_r + 1'b1;
          code_nxt   = EXC_FUNC;
          kind_nxt   = K_EXC;
          state_nxt  = bcast_w ? S_STAT : S_HEAD;
        end
      end

      S_WRRD: begin
        st_re    = 1'b1;
        st_raddr = SAW'(7 + 2 * int'(ri_r));
        state_nxt = S_WRHI;
      end

      S_WRHI: begin
        whi_nxt   = srd_r;
        st_re     = 1'b1;
        st_raddr  = SAW'(8 + 2 * int'(ri_r));
        state_nxt = S_WRLO;
      end

      S_WRLO: begin
        bk_wr    = 1'b1;
        bk_wdata = {whi_r, srd_r};
        ri_nxt   = ri_r + 1'b1;
        if (16'(ri_nxt) == qty_w) begin
          ri_nxt    = '0;
          state_nxt = bcast_r ? S_STAT : S_HEAD;
        end else begin
          state_nxt = S_WRRD;
        end
      end

      S_STAT: begin
        if (can_emit) begin
          emit      = 1'b1;
          e_valid   = 1'b0;
          e_last    = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      S_HEAD: begin
        case (kind_r)
          K_EXC: begin
            case (hidx_r)
              3'd0:    e_byte = hdr_r[0];
              3'd1:    e_byte = hdr_r[1] | EXC_FLAG;
              default: e_byte = code_r;
            endcase
          end
          K_READ: begin
            case (hidx_r)
              3'd0:    e_byte = hdr_r[0];
              3'd1:    e_byte = hdr_r[1];
              default: e_byte = {qty_w[6:0], 1'b0};
            endcase
          end
          default: e_byte = hdr_r[hidx_r];
        endcase
        if (can_emit) begin
          emit     = 1'b1;
          hidx_nxt = hidx_r + 1'b1;
          if (hidx_r == ((kind_r == K_ECHO) ? 3'd5 : 3'd2)) begin
            if (kind_r == K_READ && qty_w != '0) begin
              state_nxt = S_RDADR;
            end else begin
              state_nxt = S_CRCL;
            end
          end
        end
      end

      S_RDADR: begin
        bk_rd     = 1'b1;
        state_nxt = S_RDHI;
      end

      S_RDHI: begin
        e_byte = bk_rdata[15:8];
        if (can_emit) begin
          emit      = 1'b1;
          state_nxt = S_RDLO;
        end
      end

      S_RDLO: begin
        e_byte = bk_rdata[7:0];
        if (can_emit) begin
          emit   = 1'b1;
          ri_nxt = ri_r + 1'b1;
          state_nxt = (16'(ri_nxt) == qty_w) ? S_CRCL : S_RDADR;
        end
      end

      S_CRCL: begin
        e_byte = ocrc_r[7:0];
        if (can_emit) begin
          emit      = 1'b1;
          state_nxt = S_CRCH;
        end
      end

      S_CRCH: begin
        e_byte = ocrc_r[15:8];
        e_last = 1'b1;
        if (can_emit) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // The reply CRC runs over every emitted byte except the CRC itself.
    if (emit && state_r != S_CRCL && state_r != S_CRCH) begin
      ocrc_nxt = crc_byte(ocrc_r, e_byte);
    end
  end

  always_comb begin
    out_valid_nxt    = out_valid_r && out_stall;
    out_tx_byte_nxt  = out_tx_byte_r;
    out_tx_valid_nxt = out_tx_valid_r;
    out_tx_last_nxt  = out_tx_last_r;
    out_err_nxt      = out_err_r;
    if (emit) begin
      out_valid_nxt    = 1'b1;
      out_tx_byte_nxt  = e_byte;
      out_tx_valid_nxt = e_valid;
      out_tx_last_nxt  = e_last;
      out_err_nxt      = errors_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      pv_r        <= 1'b0;
      errors_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      pv_r        <= pv_nxt;
      errors_r    <= errors_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r            <= n_nxt;
    scan_idx_r     <= scan_idx_nxt;
    pidx_r         <= pidx_nxt;
    for (int k = 0; k < 7; k++) hdr_r[k] <= hdr_nxt[k];
    crc_r          <= crc_nxt;
    ocrc_r         <= ocrc_nxt;
    clo_r          <= clo_nxt;
    chi_r          <= chi_nxt;
    kind_r         <= kind_nxt;
    code_r         <= code_nxt;
    hidx_r         <= hidx_nxt;
    ri_r           <= ri_nxt;
    whi_r          <= whi_nxt;
    sel2_r         <= sel2_nxt;
    bank_en_r      <= bank_en_nxt;
    bcast_r        <= bcast_nxt;
    out_tx_byte_r  <= out_tx_byte_nxt;
    out_tx_valid_r <= out_tx_valid_nxt;
    out_tx_last_r  <= out_tx_last_nxt;
    out_err_r      <= out_err_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_tx_byte     = out_tx_byte_r;
  assign out_tx_valid    = out_tx_valid_r;
  assign out_tx_last     = out_tx_last_r;
  assign out_error_count = out_err_r;

endmodule

/* bench/mbrd_checker.sv */
// Checker for the dual-ID Modbus RTU slave: predicts each reply word and compares it.
`timescale 1ns / 1ps
module mbrd_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  mbrd_pkg::byte_t   cfg_data,
  input  logic              in_valid,
  input  logic              in_stall,
  input  mbrd_pkg::byte_t   in_rx_byte,
  input  logic              in_frame_end,
  input  logic              out_valid,
  input  logic              out_stall,
  input  mbrd_pkg::byte_t   out_tx_byte,
  input  logic              out_tx_valid,
  input  logic              out_tx_last,
  input  mbrd_pkg::word_t   out_error_count,
  output int                fail_count,
  output int                pending,
  output int                words_checked
);
  import mbrd_pkg::*;

  localparam int FRAME_CAP  = 64;
  localparam int BANK_WORDS = 64;

  typedef struct packed {
    byte_t tx_byte;
    logic  tx_valid;
    logic  tx_last;
    word_t err_count;
  } reply_word_t;

  reply_word_t reply_q[$];

  byte_t      id_first, id_second;
  logic [6:0] reg_count;
  byte_t      frame_buf[FRAME_CAP];
  int         fill;
  bit         overrun;
  word_t      banks[1:2][BANK_WORDS];
  word_t      err_total;

  function automatic word_t crc_of(byte_t q[$]);
    word_t c;
    c = 16'hFFFF;
    foreach (q[i]) begin
      c = c ^ {8'h00, q[i]};
      for (int b = 0; b < 8; b++) begin
        c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
      end
    end
    return c;
  endfunction

  // Counts the exception and, unless broadcast, builds the three-byte exception body.
  task automatic refuse(input byte_t fn, input byte_t code, input bit bcast,
                        inout byte_t rep[$]);
    err_total = err_total + 16'd1;
    if (!bcast) rep = '{frame_buf[0], fn | EXC_FLAG, code};
  endtask

  task automatic close_frame();
    byte_t rep[$];
    byte_t body[$];
    byte_t id, fn;
    bit    bcast;
    int    bank, regs, start, qty, stop, n;
    word_t c;
    n = fill;
    rep = {};
    if (overrun) begin
      err_total = err_total + 16'd1;
    end else if (n >= MIN_FRAME) begin
      id = frame_buf[0];
      bcast = (id == 8'd0);
      bank = (id == id_first) ? 1 : (id == id_second) ? 2 : 0;
      body = {};
      for (int i = 0; i < n - 2; i++) body.push_back(frame_buf[i]);
      c = crc_of(body);
      if ((bank != 0 || bcast) && frame_buf[n-2] == c[7:0] && frame_buf[n-1] == c[15:8]) begin
        regs  = (reg_count > BANK_WORDS) ? BANK_WORDS : reg_count;
        fn    = frame_buf[1];
        start = {frame_buf[2], frame_buf[3]};
        qty   = {frame_buf[4], frame_buf[5]};
        stop  = start + qty;
        if (fn == FN_READ && !bcast) begin
          if (start >= regs) refuse(fn, EXC_ADDR, bcast, rep);
          else if (stop > regs || READ_OVERHEAD + 2 * qty > FRAME_CAP)
            refuse(fn, EXC_VALUE, bcast, rep);
          else begin
            rep = '{id, fn, byte_t'(2 * qty)};
            for (int i = 0; i < qty; i++) begin
              rep.push_back(banks[bank][start+i][15:8]);
              rep.push_back(banks[bank][start+i][7:0]);
            end
          end
        end else if (fn == FN_WRITE1) begin
          if (start >= regs) refuse(fn, EXC_ADDR, bcast, rep);
          else begin
            if (bank != 0) banks[bank][start] = word_t'(qty);
            if (!bcast) for (int i = 0; i < 6; i++) rep.push_back(frame_buf[i]);
          end
        end else if (fn == FN_WRITEN) begin
          if (int'(frame_buf[6]) + WRN_OVERHEAD != n) err_total = err_total + 16'd1;
          else if (start >= regs) refuse(fn, EXC_ADDR, bcast, rep);
          else if (stop > regs || int'(frame_buf[6]) != 2 * qty)
            refuse(fn, EXC_VALUE, bcast, rep);
          else begin
            if (bank != 0)
              for (int i = 0; i < qty; i++)
                banks[bank][start+i] = {frame_buf[7+2*i], frame_buf[8+2*i]};
            if (!bcast) for (int i = 0; i < 6; i++) rep.push_back(frame_buf[i]);
          end
        end else begin
          refuse(fn, EXC_FUNC, bcast, rep);
        end
      end
    end
    if (rep.size() == 0) begin
      reply_q.push_back('{8'h00, 1'b0, 1'b1, err_total});
    end else begin
      c = crc_of(rep);
      rep.push_back(c[7:0]);
      rep.push_back(c[15:8]);
      foreach (rep[k])
        reply_q.push_back('{rep[k], 1'b1, k == rep.size() - 1, err_total});
    end
  endtask

  always @(posedge clk) begin
    reply_word_t exp_w;
    if (!rst_n) begin
      id_first = 8'd1;
      id_second = 8'd2;
      reg_count = 7'd64;
      fill = 0;
      overrun = 0;
      err_total = '0;
      foreach (banks[b, i]) banks[b][i] = '0;
      reply_q = {};
      fail_count = 0;
      words_checked = 0;
    end else begin
      if (out_valid && !out_stall) begin
        words_checked++;
        if (reply_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected word, actual byte %h valid %b last %b errors %0d",
                   $time, out_tx_byte, out_tx_valid, out_tx_last, out_error_count);
        end else begin
          exp_w = reply_q.pop_front();
          if (exp_w.tx_byte !== out_tx_byte || exp_w.tx_valid !== out_tx_valid ||
              exp_w.tx_last !== out_tx_last || exp_w.err_count !== out_error_count) begin
            fail_count++;
            $display("%0t: mismatch, expected byte %h valid %b last %b errors %0d, actual byte %h valid %b last %b errors %0d",
                     $time, exp_w.tx_byte, exp_w.tx_valid, exp_w.tx_last, exp_w.err_count,
                     out_tx_byte, out_tx_valid, out_tx_last, out_error_count);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_ID_FIRST:  id_first = cfg_data;
          CFG_ID_SECOND: id_second = cfg_data;
          CFG_REG_COUNT: reg_count = cfg_data[6:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (!overrun) begin
          if (fill >= FRAME_CAP) overrun = 1;
          else begin
            frame_buf[fill] = in_rx_byte;
            fill++;
          end
        end
        if (in_frame_end) begin
          close_frame();
          fill = 0;
          overrun = 0;
        end
      end
    end
    pending = reply_q.size();
  end

endmodule

/* bench/testbench.sv */
// Top of the bench for the dual-ID Modbus RTU slave: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
  import mbrd_pkg::*;

  // Quiet-time limit for the watchdog: it fires when no word moves on either side for longer than this.
  localparam int STALL_LIMIT = 20000;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_index;
  byte_t      cfg_data;
  logic       in_valid, in_stall, in_frame_end;
  byte_t      in_rx_byte;
  logic       out_valid, out_stall, out_tx_valid, out_tx_last;
  byte_t      out_tx_byte;
  word_t      out_error_count;
  int         fail_count, pending, words_checked;

  // Stimulus bookkeeping. calm turns off all random idling on both sides, and
  // long_hold asks the receiver for one long stall.
  bit    calm;
  bit    long_hold;
  int    bytes_sent;
  int    frames_sent;
  int    idle_cycles;
  byte_t cur_first, cur_second;
  int    cur_regs;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  modbus_rtu_dual_id_slave uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_rx_byte(in_rx_byte), .in_frame_end(in_frame_end),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_tx_byte(out_tx_byte), .out_tx_valid(out_tx_valid),
    .out_tx_last(out_tx_last), .out_error_count(out_error_count)
  );

  mbrd_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_rx_byte(in_rx_byte), .in_frame_end(in_frame_end),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_tx_byte(out_tx_byte), .out_tx_valid(out_tx_valid),
    .out_tx_last(out_tx_last), .out_error_count(out_error_count),
    .fail_count(fail_count), .pending(pending), .words_checked(words_checked)
  );

  // The watchdog. A correct run never goes quiet for long: the worst case is the
  // long receiver hold or the settling time after a drain.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("testbench failed");
        $finish;
      end
    end
  end

  // Receiver. Before each word it stalls for a random number of cycles, or for
  // one long stretch when asked, then takes the word as soon as it is offered.
  // Stall only changes at rising edges, and whether the word is there is looked
  // at on the falling edge, so nothing races with the block's own updates.
  initial begin
    int w;
    out_stall = 1'b0;
    @(posedge clk);
    forever begin
      w = calm ? 0 : $urandom_range(0, 18);
      if (long_hold) begin
        w = 400;
        long_hold = 0;
      end
      repeat (w) begin
        out_stall <= 1'b1;
        @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(negedge clk); while (!out_valid);
      @(posedge clk);
    end
  end

  // Offers one word after a random gap and returns just after the edge that
  // accepted it. The valid stays high when the next word follows with no gap.
  task automatic send_byte(input byte_t b, input bit fe);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_rx_byte   <= b;
    in_frame_end <= fe;
    forever begin
      @(negedge clk);
      if (!in_stall) break;
    end
    @(posedge clk);
    bytes_sent++;
  endtask

  // Sends a frame; with seal set the CRC is appended low byte first. The last
  // byte carries the frame-end flag.
  task automatic send_frame(input byte_t q[$], input bit seal);
    word_t c;
    if (seal) begin
      c = CRC_PRESET;
      foreach (q[i]) c = crc_byte(c, q[i]);
      q.push_back(c[7:0]);
      q.push_back(c[15:8]);
    end
    foreach (q[i]) send_byte(q[i], i == q.size() - 1);
    frames_sent++;
  endtask

  task automatic request(input byte_t id, input byte_t fn, input int start, input int qty);
    send_frame('{id, fn, byte_t'(start >> 8), byte_t'(start), byte_t'(qty >> 8), byte_t'(qty)},
               1'b1);
  endtask

  // Write-multiple with its own byte count field and a number of data words.
  task automatic write_many(input byte_t id, input int start, input int qty,
                            input byte_t count, input int words);
    byte_t q[$];
    q = '{id, FN_WRITEN, byte_t'(start >> 8), byte_t'(start),
          byte_t'(qty >> 8), byte_t'(qty), count};
    repeat (2 * words) q.push_back(byte_t'($urandom));
    send_frame(q, 1'b1);
  endtask

  // Waits until every reply word has come back, then lets the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (300) @(posedge clk);
  endtask

  task automatic set_reg(input logic [1:0] idx, input byte_t val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_ID_FIRST:  cur_first = val;
      CFG_ID_SECOND: cur_second = val;
      default:       cur_regs = (val[6:0] > 64) ? 64 : val[6:0];
    endcase
  endtask

  task automatic configure(input byte_t a, input byte_t b, input byte_t regs);
    set_reg(CFG_ID_FIRST, a);
    set_reg(CFG_ID_SECOND, b);
    set_reg(CFG_REG_COUNT, regs);
  endtask

  // One random frame. Most are well-formed requests to a configured station
  // with addresses near the live register range; the rest are exceptions,
  // corrupt checksums, short frames, overruns and plain noise.
  task automatic random_frame();
    byte_t q[$];
    byte_t id;
    int    r, start, qty;
    r = $urandom_range(0, 99);
    id = (r < 40) ? cur_first : (r < 75) ? cur_second : (r < 85) ? 8'd0 : byte_t'($urandom);
    start = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                        : $urandom_range(0, cur_regs + 2);
    r = $urandom_range(0, 99);
    if (r < 28) begin
      qty = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 35) : $urandom_range(0, 8);
      request(id, FN_READ, start, qty);
    end else if (r < 48) begin
      request(id, FN_WRITE1, start, $urandom_range(0, 65535));
    end else if (r < 68) begin
      qty = $urandom_range(0, 6);
      write_many(id, start, qty, byte_t'(2 * qty), qty);
    end else if (r < 72) begin
      // Byte count agrees with the frame length but not with the quantity.
      qty = $urandom_range(0, 6);
      write_many(id, start, qty + 1, byte_t'(2 * qty), qty);
    end else if (r < 76) begin
      // Byte count that disagrees with the frame length.
      qty = $urandom_range(0, 6);
      write_many(id, start, qty, byte_t'($urandom), qty);
    end else if (r < 81) begin
      request(id, byte_t'($urandom), start, $urandom_range(0, 65535));
    end else if (r < 87) begin
      q = '{id, FN_READ, 8'h00, byte_t'(start), 8'h00, 8'h01};
      q.push_back(byte_t'($urandom));
      q.push_back(byte_t'($urandom));
      send_frame(q, 1'b0);
    end else if (r < 92) begin
      repeat ($urandom_range(1, 7)) q.push_back(byte_t'($urandom));
      send_frame(q, 1'b0);
    end else if (r < 94) begin
      repeat ($urandom_range(65, 70)) q.push_back(byte_t'($urandom));
      send_frame(q, 1'b0);
    end else begin
      q.push_back(id);
      repeat ($urandom_range(7, 20)) q.push_back(byte_t'($urandom));
      send_frame(q, 1'b0);
    end
  endtask

  task automatic random_phase(input int nbytes);
    int stop_at;
    stop_at = bytes_sent + nbytes;
    while (bytes_sent < stop_at) random_frame();
  endtask

  initial begin
    byte_t q[$];
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_valid     = 1'b0;
    in_rx_byte   = '0;
    in_frame_end = 1'b0;
    calm         = 0;
    long_hold    = 0;
    bytes_sent   = 0;
    frames_sent  = 0;
    cur_first    = 8'd1;
    cur_second   = 8'd2;
    cur_regs     = 64;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames with the reset configuration: every function, each
    // exception code, the register range edges and the frames that are dropped.
    request(8'd1, FN_WRITE1, 63, 16'hFFFF);
    request(8'd1, FN_READ, 62, 2);
    request(8'd2, FN_READ, 0, 0);
    write_many(8'd2, 0, 2, 8'd4, 2);
    request(8'd2, FN_READ, 0, 2);
    request(8'd1, FN_READ, 64, 1);
    request(8'd1, FN_READ, 62, 3);
    request(8'd1, FN_READ, 0, 30);
    request(8'hFF, FN_READ, 16'hFFFF, 16'hFFFF);
    write_many(8'd1, 0, 3, 8'd4, 2);
    write_many(8'd1, 0, 2, 8'd5, 2);
    request(8'd1, 8'h2B, 0, 1);
    request(8'd0, FN_WRITE1, 5, 16'h1234);
    request(8'd0, FN_READ, 0, 1);
    request(8'd7, FN_READ, 0, 1);
    q = '{8'd1, FN_READ, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00};
    send_frame(q, 1'b0);
    q = '{8'd1, FN_READ, 8'h00, 8'h00, 8'h00};
    send_frame(q, 1'b1);
    q = {};
    repeat (66) q.push_back(byte_t'($urandom));
    send_frame(q, 1'b0);
    drain();

    // Broadcast address configured as the first station, one live register.
    configure(8'd0, 8'd255, 8'd1);
    request(8'd0, FN_WRITE1, 0, 16'hBEEF);
    write_many(8'd0, 0, 1, 8'd2, 1);
    request(8'd255, FN_READ, 0, 1);
    random_phase(15);
    drain();

    // Register count above the bank size is clipped; broadcast as the second ID.
    calm = 1;
    configure(8'd255, 8'd0, 8'd127);
    random_phase(15);
    // The sender stops here until every reply has come back.
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
    random_phase(5);
    drain();

    // Long receiver hold while requests keep arriving, so the input backs up.
    calm = 0;
    configure(8'd1, 8'd2, 8'd64);
    long_hold = 1;
    request(8'd1, FN_READ, 0, 29);
    random_phase(15);
    drain();

    // No live registers: every addressed read or write request is out of range.
    calm = 1;
    configure(8'h5A, 8'hA5, 8'd0);
    random_phase(10);
    drain();

    calm = 0;
    configure(byte_t'($urandom_range(1, 255)), byte_t'($urandom_range(1, 255)),
              byte_t'($urandom_range(1, 64)));
    random_phase(20);
    drain();

    configure(8'h80, 8'h7F, 8'd8);
    random_phase(20);
    drain();

    $display("Sent %0d bytes in %0d frames over seven register settings.",
             bytes_sent, frames_sent);
    $display("Checked %0d reply words, %0d mismatches.", words_checked, fail_count);
    if (fail_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

/* files.f */
design/mbrd_pkg.sv
design/mbrd_bank.sv
design/modbus_rtu_dual_id_slave.sv
bench/mbrd_checker.sv
bench/testbench.sv
